/* rtl/fdes_pkg.sv */
// ----------------------------------------------------------------------------
// fdes_pkg
// Shared types and constants for the FAT16 root directory entry search.
// ----------------------------------------------------------------------------
package fdes_pkg;

	localparam int unsigned ByteW       = 8;
	localparam int unsigned PosW        = 5;
	localparam int unsigned CountW      = 16;
	localparam int unsigned BaseNameW   = 64;
	localparam int unsigned ExtW        = 24;
	localparam int unsigned CfgDataW    = 64;
	localparam int unsigned CfgIndexW   = 2;

	localparam logic [ByteW-1:0]  DeletedMark  = 8'hE5;
	localparam logic [ByteW-1:0]  EndMark      = 8'h00;
	localparam logic [ByteW-1:0]  AttrSkipMask = 8'h12;

	localparam logic [PosW-1:0] NameBytes     = 5'd11;
	localparam logic [PosW-1:0] AttrOffset    = 5'd11;
	localparam logic [PosW-1:0] TimeOffset    = 5'd22;
	localparam logic [PosW-1:0] DateOffset    = 5'd24;
	localparam logic [PosW-1:0] ClusterOffset = 5'd26;
	localparam logic [PosW-1:0] SizeOffset    = 5'd28;
	localparam logic [PosW-1:0] LastByte      = 5'd31;

	localparam logic [CountW-1:0] CountMax       = 16'hFFFF;
	localparam logic [CountW-1:0] EntryLimitInit = 16'd512;

	typedef enum logic [1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_END_MARK  = 2'd1,
		STATUS_LIMIT_HIT = 2'd2
	} status_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_BASE_NAME   = 2'd0,
		REG_EXTENSION   = 2'd1,
		REG_ENTRY_LIMIT = 2'd2
	} cfg_reg_t;

endpackage

/* rtl/fdes_if.sv */
// ----------------------------------------------------------------------------
// fdes_if
// Valid/ready channels: directory bytes in, search results out.
// ----------------------------------------------------------------------------
interface fdes_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] dir_byte;
	logic       start_search;

	modport source (output valid, output dir_byte, output start_search, input ready);
	modport sink   (input valid, input dir_byte, input start_search, output ready);
endinterface

interface fdes_out_if;
	logic                 valid;
	logic                 ready;
	fdes_pkg::status_t    status;
	logic [15:0]          entry_index;
	logic [15:0]          mod_time;
	logic [15:0]          mod_date;
	logic [31:0]          file_length;
	logic [15:0]          first_cluster;

	modport source (output valid, output status, output entry_index, output mod_time,
		output mod_date, output file_length, output first_cluster, input ready);
	modport sink   (input valid, input status, input entry_index, input mod_time,
		input mod_date, input file_length, input first_cluster, output ready);
endinterface

/* rtl/fat16_directory_entry_search.sv */
// ----------------------------------------------------------------------------
// fat16_directory_entry_search
// Scans a byte stream of 32-byte root directory entries for an 8.3 name.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                        handshake
//  in_ch     in    dir_byte, start_search                          valid/ready
//  out_ch    out   status, entry_index, mod_time, mod_date,        valid/ready
//                  file_length, first_cluster
//  cfg       in    cfg_wr_en, cfg_index, cfg_data                  write only
//
//  one byte per cycle while the result register is free; a byte is registered,
//  then evaluated combinationally against the entry state into the result register
//  arst_n clears the stage, result valid and search state (idle until start)
//  a held result stalls the input register and the search state; at most one more
//  byte is taken while the result waits
module fat16_directory_entry_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	fdes_in_if.sink                              in_ch,
	fdes_out_if.source                           out_ch,
	input  logic                                 cfg_wr_en,
	input  logic [fdes_pkg::CfgIndexW-1:0]       cfg_index,
	input  logic [fdes_pkg::CfgDataW-1:0]        cfg_data
);

	// configuration
	logic [fdes_pkg::BaseNameW-1:0] base_name_q;
	logic [fdes_pkg::ExtW-1:0]      ext_q;
	logic [fdes_pkg::CountW-1:0]    limit_q;

	// input stage
	logic                       valid_s1;
	logic [fdes_pkg::ByteW-1:0] byte_s1;
	logic                       start_s1;

	// search state
	logic [fdes_pkg::PosW-1:0]   pos_q;
	logic [fdes_pkg::CountW-1:0] count_q;
	logic                        match_q;
	logic                        skip_q;
	logic                        finished_q;
	logic [15:0]                 time_q;
	logic [15:0]                 date_q;
	logic [31:0]                 size_q;
	logic [15:0]                 cluster_q;

	// result register
	logic                        out_valid_q;
	fdes_pkg::status_t           status_q;
	logic [15:0]                 index_q;
	logic [15:0]                 otime_q;
	logic [15:0]                 odate_q;
	logic [31:0]                 olen_q;
	logic [15:0]                 ocluster_q;

	logic                        out_free;
	logic                        advance;

	// next state
	logic                        fin_c;
	logic [fdes_pkg::PosW-1:0]   pos_c;
	logic [fdes_pkg::CountW-1:0] count_c;
	logic                        match_c;
	logic                        skip_c;
	logic [fdes_pkg::PosW-1:0]   pos_n;
	logic [fdes_pkg::CountW-1:0] count_n;
	logic                        match_n;
	logic                        skip_n;
	logic                        finished_n;
	logic [127:0]                name_vec;
	logic [fdes_pkg::ByteW-1:0]  target_byte;
	logic                        emit;
	fdes_pkg::status_t           emit_status;
	logic [31:0]                 len_c;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign advance     = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_name_q <= '0;
			ext_q       <= '0;
			limit_q     <= fdes_pkg::EntryLimitInit;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fdes_pkg::REG_BASE_NAME:   base_name_q <= cfg_data;
				fdes_pkg::REG_EXTENSION:   ext_q       <= cfg_data[fdes_pkg::ExtW-1:0];
				fdes_pkg::REG_ENTRY_LIMIT: limit_q     <= cfg_data[fdes_pkg::CountW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1  <= in_ch.dir_byte;
			start_s1 <= in_ch.start_search;
		end
	end

	// name bytes 0..10 as one vector, upper slots unused
	assign name_vec    = {40'd0, ext_q, base_name_q};
	assign target_byte = name_vec[pos_c[3:0]*8 +: 8];

	always_comb begin
		fin_c   = start_s1 ? 1'b0 : finished_q;
		pos_c   = start_s1 ? '0 : pos_q;
		count_c = start_s1 ? '0 : count_q;
		match_c = start_s1 ? 1'b1 : match_q;
		skip_c  = start_s1 ? 1'b0 : skip_q;

		pos_n       = pos_c;
		count_n     = count_c;
		match_n     = match_c;
		skip_n      = skip_c;
		finished_n  = fin_c;
		emit        = 1'b0;
		emit_status = fdes_pkg::STATUS_FOUND;
		len_c       = {byte_s1, size_q[23:0]};

		if (!fin_c) begin
			if (pos_c == '0 && byte_s1 == fdes_pkg::EndMark) begin
				emit        = 1'b1;
				emit_status = fdes_pkg::STATUS_END_MARK;
				finished_n  = 1'b1;
			end else begin
				if (pos_c == '0 && byte_s1 == fdes_pkg::DeletedMark)
					skip_n = 1'b1;
				if (pos_c == fdes_pkg::AttrOffset && (byte_s1 & fdes_pkg::AttrSkipMask) != '0)
					skip_n = 1'b1;
				if (pos_c < fdes_pkg::NameBytes && byte_s1 != target_byte)
					match_n = 1'b0;

				if (pos_c != fdes_pkg::LastByte) begin
					pos_n = pos_c + 1'b1;
				end else if (!skip_n && match_n) begin
					emit        = 1'b1;
					emit_status = fdes_pkg::STATUS_FOUND;
					finished_n  = 1'b1;
				end else begin
					// saturate so the count never wraps
					if (count_c != fdes_pkg::CountMax)
						count_n = count_c + 1'b1;
					pos_n   = '0;
					match_n = 1'b1;
					skip_n  = 1'b0;
					if (count_n >= limit_q) begin
						emit        = 1'b1;
						emit_status = fdes_pkg::STATUS_LIMIT_HIT;
						finished_n  = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			count_q    <= '0;
			match_q    <= 1'b1;
			skip_q     <= 1'b0;
			finished_q <= 1'b1;
		end else if (advance) begin
			pos_q      <= pos_n;
			count_q    <= count_n;
			match_q    <= match_n;
			skip_q     <= skip_n;
			finished_q <= finished_n;
		end
	end

	// field capture; every field is rewritten before an entry can match
	always_ff @(posedge clk) begin
		if (advance && !fin_c) begin
			case (pos_c)
				fdes_pkg::TimeOffset:          time_q[7:0]     <= byte_s1;
				fdes_pkg::TimeOffset + 5'd1:   time_q[15:8]    <= byte_s1;
				fdes_pkg::DateOffset:          date_q[7:0]     <= byte_s1;
				fdes_pkg::DateOffset + 5'd1:   date_q[15:8]    <= byte_s1;
				fdes_pkg::ClusterOffset:       cluster_q[7:0]  <= byte_s1;
				fdes_pkg::ClusterOffset + 5'd1: cluster_q[15:8] <= byte_s1;
				fdes_pkg::SizeOffset:          size_q[7:0]     <= byte_s1;
				fdes_pkg::SizeOffset + 5'd1:   size_q[15:8]    <= byte_s1;
				fdes_pkg::SizeOffset + 5'd2:   size_q[23:16]   <= byte_s1;
				fdes_pkg::SizeOffset + 5'd3:   size_q[31:24]   <= byte_s1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			status_q <= emit_status;
			if (emit_status == fdes_pkg::STATUS_FOUND) begin
				index_q    <= count_c;
				otime_q    <= time_q;
				odate_q    <= date_q;
				olen_q     <= len_c;
				ocluster_q <= cluster_q;
			end else begin
				index_q    <= '0;
				otime_q    <= '0;
				odate_q    <= '0;
				olen_q     <= '0;
				ocluster_q <= '0;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_q;
	assign out_ch.entry_index   = index_q;
	assign out_ch.mod_time      = otime_q;
	assign out_ch.mod_date      = odate_q;
	assign out_ch.file_length   = olen_q;
	assign out_ch.first_cluster = ocluster_q;

endmodule

/* rtl/fdes_checker.sv */
// ----------------------------------------------------------------------------
// fdes_checker
// Port-level checks for the directory entry search, bound to the top level.
// ----------------------------------------------------------------------------
module fdes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] entry_index,
	input logic [15:0] mod_time,
	input logic [15:0] mod_date,
	input logic [31:0] file_length,
	input logic [15:0] first_cluster
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_index)
			&& $stable(file_length))
		else $error("result changed while stalled");

	// no result straight out of reset
	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

	// an empty result register always frees the input side
	a_in_free: assert property (@(posedge clk) !out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// only a found result carries entry fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fdes_pkg::STATUS_FOUND |->
			entry_index == '0 && mod_time == '0 && mod_date == '0
			&& file_length == '0 && first_cluster == '0)
		else $error("miss result carries entry fields");

endmodule

bind fat16_directory_entry_search fdes_checker u_fdes_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.status        (out_ch.status),
	.entry_index   (out_ch.entry_index),
	.mod_time      (out_ch.mod_time),
	.mod_date      (out_ch.mod_date),
	.file_length   (out_ch.file_length),
	.first_cluster (out_ch.first_cluster)
);
